/* sv/gds_pkg.sv */
package gds_pkg;

	localparam int DN_W = 24;
	localparam int MUL_A_W = 14;
	localparam int MUL_B_W = 13;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [DN_W-1:0] DAYS_400 = 24'd146097;
	localparam logic [DN_W-1:0] DAYS_100 = 24'd36524;
	localparam logic [DN_W-1:0] DAYS_4   = 24'd1461;
	localparam logic [DN_W-1:0] DAYS_1   = 24'd365;

	// x/25 == (x*5243)>>17 for x < 4096
	localparam logic [MUL_B_W-1:0] RECIP_25 = 13'd5243;
	localparam int RECIP_SH = 17;

	typedef enum logic [1:0] {
		MODE_SET  = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_SUB  = 2'd2,
		MODE_DIFF = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_SAT  = 2'd2,
		STAT_RSVD = 2'd3
	} status_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			case (m)
				4'd2: len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

	// days before the first of month m in a common year
	function automatic logic [8:0] month_cum(input logic [3:0] m);
		logic [8:0] c;
		begin
			case (m)
				4'd2: c = 9'd31;
				4'd3: c = 9'd59;
				4'd4: c = 9'd90;
				4'd5: c = 9'd120;
				4'd6: c = 9'd151;
				4'd7: c = 9'd181;
				4'd8: c = 9'd212;
				4'd9: c = 9'd243;
				4'd10: c = 9'd273;
				4'd11: c = 9'd304;
				4'd12: c = 9'd334;
				default: c = 9'd0;
			endcase
			return c;
		end
	endfunction

endpackage

/* sv/gds_req_if.sv */
interface gds_req_if import gds_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [4:0]  in_day;
	logic [3:0]  in_month;
	logic [13:0] in_year;
	logic [21:0] day_count;

	modport source (output valid, mode, in_day, in_month, in_year, day_count, input ready);
	modport sink (input valid, mode, in_day, in_month, in_year, day_count, output ready);
endinterface

/* sv/gds_rsp_if.sv */
interface gds_rsp_if import gds_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [4:0]  cur_day;
	logic [3:0]  cur_month;
	logic [13:0] cur_year;
	logic [21:0] distance;
	logic [1:0]  status;

	modport source (output valid, cur_day, cur_month, cur_year, distance, status, input ready);
	modport sink (input valid, cur_day, cur_month, cur_year, distance, status, output ready);
endinterface

/* sv/gregorian_date_stepper_core.sv */
// Gregorian date stepper. Holds one date (reset: 01.01.0001).
// req channel: one request per command (mode, in_day, in_month, in_year,
// day_count), accepted when req.valid and req.ready are high. ready is high
// only while the block is idle; one request is worked on at a time.
// rsp channel: one result per request carrying the held date after the
// command, the distance (mode 3) and a status code. The result is held on
// rsp until rsp.ready; the block takes no new request meanwhile.
// Set and difference convert the held date, then the input date, to day
// numbers on the shared multiplier (ST_DN). Add and subtract convert the
// held date, step it (ST_STEP), split it in a 15-step divide into 400-, 100-,
// 4- and 1-year counts (ST_DIV, ST_YR), find the year's leap flag (ST_DN) and
// walk the months (ST_MON); divide and month walk share one compare/subtract.
// The next request is taken the cycle after the result is accepted.
// Reset clears the date to 01.01.0001 and returns to idle.
module gregorian_date_stepper_core import gds_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic      clk,
	input  logic      arst_n,
	gds_req_if.sink   req,
	gds_rsp_if.source rsp
);
	localparam int LP = MAX_YEAR - 1;
	localparam int LAST_LEAP =
		(((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0)) || ((MAX_YEAR % 400) == 0) ? 1 : 0;
	localparam logic [DN_W-1:0] LAST_DN =
		DN_W'(LP * 365 + LP / 4 - LP / 100 + LP / 400 + 365 + LAST_LEAP);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DN   = 7'b0000010,
		ST_STEP = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_YR   = 7'b0010000,
		ST_MON  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		DN_HELD = 2'd0,
		DN_IN   = 2'd1,
		DN_YY   = 2'd2,
		DN_NONE = 2'd3
	} dn_sel_t;

	typedef enum logic [1:0] {
		PH400 = 2'd0,
		PH100 = 2'd1,
		PH4   = 2'd2,
		PH1   = 2'd3
	} phase_t;

	state_t  state_q;
	dn_sel_t sel_q;
	phase_t  phase_q;

	logic [1:0]      mode_q;
	logic [4:0]      d_in_q;
	logic [3:0]      m_in_q;
	logic [13:0]     y_in_q;
	logic [21:0]     cnt_q;
	logic [4:0]      held_day_q;
	logic [3:0]      held_month_q;
	logic [13:0]     held_year_q;
	logic [4:0]      dn_d_q;
	logic [3:0]      dn_m_q;
	logic [13:0]     dn_y_q;
	logic [2:0]      step_q;
	logic [7:0]      t100_q;
	logic [7:0]      t400_q;
	logic            y100_q;
	logic            leap_q;
	logic [DN_W-1:0] cur_q;
	logic [21:0]     dist_q;
	logic [1:0]      status_q;
	logic [DN_W-1:0] rem_q;
	logic [2:0]      k_q;
	logic [5:0]      q400_q;
	logic [1:0]      q100_q;
	logic [4:0]      q4_q;
	logic [1:0]      q1_q;
	logic [3:0]      mm_q;

	logic [13:0]        p;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic [13:0]        prod_lo;
	logic [DN_W-1:0]    dn_sum;
	logic [DN_W-1:0]    cs_b;
	logic [DN_W-1:0]    div_base;
	logic               cs_ge;
	logic [DN_W-1:0]    cs_diff;
	logic [4:0]         mlen;
	logic [4:0]         in_len;
	logic               in_ok;
	logic [13:0]        yy;
	logic [DN_W-1:0]    step_n;
	logic [1:0]         step_st;
	logic [DN_W-1:0]    absd;

	assign p = dn_y_q - 14'd1;

	always_comb begin
		case (step_q)
			3'd0: begin mul_a = MUL_A_W'(p >> 2); mul_b = RECIP_25; end
			3'd1: begin mul_a = MUL_A_W'(p >> 4); mul_b = RECIP_25; end
			3'd2: begin mul_a = MUL_A_W'(t100_q); mul_b = 13'd100; end
			3'd3: begin mul_a = MUL_A_W'(t400_q); mul_b = 13'd400; end
			default: begin mul_a = p; mul_b = 13'd365; end
		endcase
	end

	assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign prod_lo = prod[13:0];

	assign dn_sum = DN_W'(prod) + DN_W'(p >> 2) - DN_W'(t100_q) + DN_W'(t400_q)
		+ DN_W'(month_cum(dn_m_q)) + DN_W'(leap_q && (dn_m_q > 4'd2))
		+ DN_W'(dn_d_q);

	always_comb begin
		case (phase_q)
			PH400: div_base = DAYS_400;
			PH100: div_base = DAYS_100;
			PH4:   div_base = DAYS_4;
			default: div_base = DAYS_1;
		endcase
	end

	assign mlen = month_len(mm_q, leap_q);
	assign cs_b = state_q == ST_MON ? DN_W'(mlen) : (div_base << k_q);

	gds_cmp_sub u_cs (
		.a    (rem_q),
		.b    (cs_b),
		.ge   (cs_ge),
		.diff (cs_diff)
	);

	assign in_len = month_len(m_in_q, leap_q);
	assign in_ok = (m_in_q >= 4'd1) && (m_in_q <= 4'd12) && (y_in_q >= 14'd1)
		&& (y_in_q <= 14'(MAX_YEAR)) && (d_in_q >= 5'd1) && (d_in_q <= in_len);

	assign absd = dn_sum > cur_q ? dn_sum - cur_q : cur_q - dn_sum;

	assign yy = 14'(q400_q) * 14'd400 + 14'(q100_q) * 14'd100 + 14'({q4_q, 2'b00})
		+ 14'(q1_q) + 14'd1;

	always_comb begin
		step_st = STAT_OK;
		if (mode_q == MODE_ADD) begin
			if (DN_W'(cnt_q) > LAST_DN - cur_q) begin
				step_n = LAST_DN;
				step_st = STAT_SAT;
			end else begin
				step_n = cur_q + DN_W'(cnt_q);
			end
		end else begin
			if (DN_W'(cnt_q) >= cur_q) begin
				step_n = DN_W'(1);
				step_st = STAT_SAT;
			end else begin
				step_n = cur_q - DN_W'(cnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_day_q <= 5'd1;
			held_month_q <= 4'd1;
			held_year_q <= 14'd1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q <= req.mode;
						d_in_q <= req.in_day;
						m_in_q <= req.in_month;
						y_in_q <= req.in_year;
						cnt_q <= req.day_count;
						dist_q <= '0;
						status_q <= STAT_OK;
						dn_d_q <= held_day_q;
						dn_m_q <= held_month_q;
						dn_y_q <= held_year_q;
						sel_q <= DN_HELD;
						step_q <= 3'd0;
						state_q <= ST_DN;
					end
				end
				ST_DN: begin
					step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
					case (step_q)
						3'd0: t100_q <= prod[RECIP_SH+7:RECIP_SH];
						3'd1: t400_q <= prod[RECIP_SH+7:RECIP_SH];
						3'd2: y100_q <= (p - prod_lo) == 14'd99;
						3'd3: begin
							leap_q <= (p[1:0] == 2'd3) && (!y100_q || ((p - prod_lo) == 14'd399));
							if (sel_q == DN_YY) begin
								mm_q <= 4'd1;
								state_q <= ST_MON;
							end
						end
						default: begin
							if (sel_q == DN_HELD) begin
								cur_q <= dn_sum;
								if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
									state_q <= ST_STEP;
								end else begin
									dn_d_q <= d_in_q;
									dn_m_q <= m_in_q;
									dn_y_q <= y_in_q;
									sel_q <= DN_IN;
								end
							end else begin
								if (!in_ok) begin
									status_q <= STAT_BAD;
								end else if (mode_q == MODE_SET) begin
									held_day_q <= d_in_q;
									held_month_q <= m_in_q;
									held_year_q <= y_in_q;
								end else begin
									dist_q <= absd[21:0];
								end
								state_q <= ST_OUT;
							end
						end
					endcase
				end
				ST_STEP: begin
					rem_q <= step_n - DN_W'(1);
					status_q <= step_st;
					phase_q <= PH400;
					k_q <= 3'd5;
					q400_q <= '0;
					q100_q <= '0;
					q4_q <= '0;
					q1_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cs_ge) begin
						rem_q <= cs_diff;
						case (phase_q)
							PH400: q400_q[k_q] <= 1'b1;
							PH100: q100_q[k_q[0]] <= 1'b1;
							PH4:   q4_q[k_q] <= 1'b1;
							default: q1_q[k_q[0]] <= 1'b1;
						endcase
					end
					if (k_q == 3'd0) begin
						case (phase_q)
							PH400: begin phase_q <= PH100; k_q <= 3'd1; end
							PH100: begin phase_q <= PH4; k_q <= 3'd4; end
							PH4:   begin phase_q <= PH1; k_q <= 3'd1; end
							default: state_q <= ST_YR;
						endcase
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				ST_YR: begin
					dn_y_q <= yy;
					sel_q <= DN_YY;
					step_q <= 3'd0;
					state_q <= ST_DN;
				end
				ST_MON: begin
					if (cs_ge && mm_q < 4'd12) begin
						rem_q <= cs_diff;
						mm_q <= mm_q + 4'd1;
					end else begin
						held_day_q <= rem_q[4:0] + 5'd1;
						held_month_q <= mm_q;
						held_year_q <= dn_y_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready = state_q == ST_IDLE;
	assign rsp.valid = state_q == ST_OUT;
	assign rsp.cur_day = held_day_q;
	assign rsp.cur_month = held_month_q;
	assign rsp.cur_year = held_year_q;
	assign rsp.distance = dist_q;
	assign rsp.status = status_q;
endmodule

/* sv/gds_cmp_sub.sv */
module gds_cmp_sub import gds_pkg::*; (
	input  logic [DN_W-1:0] a,
	input  logic [DN_W-1:0] b,
	output logic            ge,
	output logic [DN_W-1:0] diff
);
	logic [DN_W:0] d;

	assign d = {1'b0, a} - {1'b0, b};
	assign ge = ~d[DN_W];
	assign diff = d[DN_W-1:0];
endmodule
